// ----- hw/rtl/rcfb_pkg.sv -----
// Shared types, constants and the CRC-8 byte update for the RC channel frame builder.
// Used by every module of the block; it depends on nothing else.
`default_nettype none

package rcfb_pkg;

	localparam int CHAN_W        = 11;
	localparam int CH_IDX_W      = 4;
	localparam int BUF_W         = 18;
	localparam int HELD_W        = 5;
	localparam int OUT_DEPTH     = 2;
	localparam int DEFAULT_QUEUE_DEPTH = 4;

	localparam logic [CH_IDX_W-1:0] FIRST_CHANNEL = 4'd0;
	localparam logic [CH_IDX_W-1:0] LAST_CHANNEL  = 4'd15;

	localparam logic [7:0] SYNC_RESET   = 8'hEE;
	localparam logic [7:0] FRAME_LENGTH = 8'd24;
	localparam logic [7:0] FRAME_TYPE   = 8'h16;
	localparam logic [7:0] CRC_POLY     = 8'hD5;

	localparam logic [HELD_W-1:0] BYTE_BITS = 5'd8;
	localparam logic [HELD_W-1:0] CHAN_BITS = 5'd11;
	localparam logic [HELD_W-1:0] MAX_HELD  = 5'd18;

	// One accepted channel, classified by its place in the frame.
	typedef struct packed {
		logic [CHAN_W-1:0] value;
		logic [7:0]        sync;
		logic              first;
		logic              last;
	} item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SYNC,
		BK_LEN,
		BK_TYPE,
		BK_DATA,
		BK_CRC
	} back_state_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rcfb_front.sv -----
// Front end: accepts channel values, tracks the channel index and the sync register,
// and tags each channel for the back end. Depends on rcfb_pkg.
`default_nettype none

module rcfb_front
	import rcfb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic [CHAN_W-1:0] channel_value,
	input  wire logic              cfg_we,
	input  wire logic [7:0]        cfg_wdata,
	output logic                   q_wr,
	output item_t                  q_wdata,
	input  wire logic              q_full
);

	logic [CH_IDX_W-1:0] chan_idx_q;
	logic [7:0]          sync_q;

	assign full = q_full;
	assign q_wr = push && !q_full;

	always_comb begin
		q_wdata.value = channel_value;
		q_wdata.sync  = sync_q;
		q_wdata.first = (chan_idx_q == FIRST_CHANNEL);
		q_wdata.last  = (chan_idx_q == LAST_CHANNEL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_idx_q <= '0;
			sync_q     <= SYNC_RESET;
		end else begin
			if (q_wr) begin
				chan_idx_q <= chan_idx_q + 1'b1;
			end
			if (cfg_we) begin
				sync_q <= cfg_wdata;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/rcfb_queue.sv -----
// Small item queue between the front and back ends of the frame builder.
// Depends on rcfb_pkg for the item type.
`default_nettype none

module rcfb_queue
	import rcfb_pkg::*;
#(
	parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr_en,
	input  item_t      wr_data,
	output logic       full,
	input  wire logic  rd_en,
	output item_t      rd_data,
	output logic       empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/rcfb_back.sv -----
// Back end: packs channel bits into bytes, emits header, payload and CRC bytes
// into a two-entry result queue. Depends on rcfb_pkg.
`default_nettype none

module rcfb_back
	import rcfb_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_empty,
	output logic       q_rd,
	input  item_t      q_rdata,
	output logic       empty,
	input  wire logic  pop,
	output logic [7:0] frame_byte,
	output logic       last_byte
);

	back_state_t       state_q, state_d;
	logic [BUF_W-1:0]  buf_q, buf_d;
	logic [HELD_W-1:0] held_q, held_d;
	logic [7:0]        crc_q, crc_d;
	logic [7:0]        sync_q, sync_d;
	logic              last_q, last_d;

	logic              emit;
	out_t              emit_data;
	logic              emit_ok;

	logic [BUF_W-1:0]  base_buf;
	logic [2:0]        base_held;
	logic [HELD_W-1:0] held_after;

	out_t              out_mem_q [OUT_DEPTH];
	logic              out_wr_ptr_q;
	logic              out_rd_ptr_q;
	logic [1:0]        out_cnt_q;
	logic              out_pop;

	assign emit_ok    = (out_cnt_q != 2'(OUT_DEPTH));
	assign held_after = held_q - BYTE_BITS;

	always_comb begin
		// Only the bits below held survive; a new frame starts from an empty buffer.
		base_held = q_rdata.first ? 3'd0 : held_q[2:0];
		base_buf  = q_rdata.first ? '0 : (buf_q & ~({BUF_W{1'b1}} << base_held));
	end

	always_comb begin
		state_d   = state_q;
		buf_d     = buf_q;
		held_d    = held_q;
		crc_d     = crc_q;
		sync_d    = sync_q;
		last_d    = last_q;
		q_rd      = 1'b0;
		emit      = 1'b0;
		emit_data = '0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_rd    = 1'b1;
					buf_d   = base_buf | (BUF_W'(q_rdata.value) << base_held);
					held_d  = HELD_W'(base_held) + CHAN_BITS;
					sync_d  = q_rdata.sync;
					last_d  = q_rdata.last;
					state_d = q_rdata.first ? BK_SYNC : BK_DATA;
				end
			end
			BK_SYNC: begin
				if (emit_ok) begin
					emit           = 1'b1;
					emit_data.data = sync_q;
					state_d        = BK_LEN;
				end
			end
			BK_LEN: begin
				if (emit_ok) begin
					emit           = 1'b1;
					emit_data.data = FRAME_LENGTH;
					state_d        = BK_TYPE;
				end
			end
			BK_TYPE: begin
				if (emit_ok) begin
					emit           = 1'b1;
					emit_data.data = FRAME_TYPE;
					crc_d          = crc8_update(8'h00, FRAME_TYPE);
					state_d        = BK_DATA;
				end
			end
			BK_DATA: begin
				if (emit_ok) begin
					emit           = 1'b1;
					emit_data.data = buf_q[7:0];
					crc_d          = crc8_update(crc_q, buf_q[7:0]);
					buf_d          = buf_q >> 8;
					held_d         = held_after;
					if (held_after < BYTE_BITS) begin
						state_d = last_q ? BK_CRC : BK_IDLE;
					end
				end
			end
			BK_CRC: begin
				if (emit_ok) begin
					emit           = 1'b1;
					emit_data.data = crc_q;
					emit_data.last = 1'b1;
					buf_d          = '0;
					held_d         = '0;
					state_d        = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			held_q  <= '0;
			buf_q   <= '0;
			crc_q   <= '0;
		end else begin
			state_q <= state_d;
			held_q  <= held_d;
			buf_q   <= buf_d;
			crc_q   <= crc_d;
		end
	end

	always_ff @(posedge clk) begin
		sync_q <= sync_d;
		last_q <= last_d;
	end

	// Result queue: lets the packer run ahead while the receiver stalls.
	assign empty      = (out_cnt_q == 2'd0);
	assign out_pop    = pop && !empty;
	assign frame_byte = out_mem_q[out_rd_ptr_q].data;
	assign last_byte  = out_mem_q[out_rd_ptr_q].last;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_mem_q[out_wr_ptr_q] <= emit_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_ptr_q <= 1'b0;
			out_rd_ptr_q <= 1'b0;
			out_cnt_q    <= 2'd0;
		end else begin
			if (emit) begin
				out_wr_ptr_q <= ~out_wr_ptr_q;
			end
			if (out_pop) begin
				out_rd_ptr_q <= ~out_rd_ptr_q;
			end
			if (emit && !out_pop) begin
				out_cnt_q <= out_cnt_q + 2'd1;
			end else if (out_pop && !emit) begin
				out_cnt_q <= out_cnt_q - 2'd1;
			end
		end
	end

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= MAX_HELD)
		else $error("bit buffer holds more bits than it can");

	a_crc_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_CRC) |-> last_q)
		else $error("CRC byte scheduled for a channel that does not end the frame");

	a_payload_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_CRC) |-> (held_q == '0))
		else $error("payload bits left over when the CRC byte goes out");

	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= 2'(OUT_DEPTH))
		else $error("result queue overflow");

	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$past(emit) |-> !empty)
		else $error("emitted byte did not reach the result queue");

endmodule

`default_nettype wire

// ----- hw/rtl/rc_channel_frame_builder_core.sv -----
// Top level of the RC channel frame builder: front end, item queue and back end.
// Depends on rcfb_pkg, rcfb_front, rcfb_queue and rcfb_back.
//
// Usage: channel values for channels 0 to 15 are pushed in order on push/full;
// a transaction completes when push is high and full is low. Frame bytes come out
// on frame_byte/last_byte while empty is low and are taken with pop. Each frame is
// 26 bytes: sync address, length 24, type 0x16, 22 packed payload bytes and a
// CRC-8 byte flagged by last_byte. cfg_we/cfg_wdata write the sync address, which
// is sampled when channel 0 is accepted.
// Flow: the back end loads a channel from the item queue in its idle state and then
// emits its bytes (1 to 4) one per cycle while the result queue has room; it takes
// the next channel only once those bytes are out, so the byte packer is the limit.
// The front end takes a new channel every cycle until the item queue (QUEUE_DEPTH
// entries) fills.
// When the receiver stalls, the two-entry result queue fills, the packer stops,
// and then the item queue fills and raises full. Reset empties both queues,
// restarts at channel 0 and sets the sync address to 0xEE.
`default_nettype none

module rc_channel_frame_builder_core
	import rcfb_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic [CHAN_W-1:0] channel_value,
	output logic                   empty,
	input  wire logic              pop,
	output logic [7:0]             frame_byte,
	output logic                   last_byte,
	input  wire logic              cfg_we,
	input  wire logic [7:0]        cfg_wdata
);

	logic  q_wr;
	item_t q_wdata;
	logic  q_full;
	logic  q_rd;
	item_t q_rdata;
	logic  q_empty;

	rcfb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.channel_value (channel_value),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.q_wr          (q_wr),
		.q_wdata       (q_wdata),
		.q_full        (q_full)
	);

	rcfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	rcfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_rd       (q_rd),
		.q_rdata    (q_rdata),
		.empty      (empty),
		.pop        (pop),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule

`default_nettype wire
